@@ hdl/fuxc_pkg.sv @@
// ----------------------------------------------------------------------------
// fuxc_pkg
// Shared constants and types for the frame unescape / XOR check block.
// ----------------------------------------------------------------------------
package fuxc_pkg;

    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_CODE_ESC  = 8'h01;
    localparam logic [7:0] ESC_CODE_FLAG = 8'h02;

    localparam int QUEUE_DEPTH = 4;

    // One or two unescaped bytes produced by one escaped input byte.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic       last0;
        logic [7:0] byte1;
        logic       last1;
    } pair_t;

endpackage

@@ hdl/frame_unescape_xor_check.sv @@
// ----------------------------------------------------------------------------
// frame_unescape_xor_check
// Byte unstuffing (7D 01 -> 7D, 7D 02 -> 7E) with XOR check and frame length.
// ----------------------------------------------------------------------------
// Takes one escaped byte per cycle while the queue has room and sends out one
// unescaped byte per cycle while the output is ready. An escaped byte yields
// zero, one or two output bytes (two only for a 7D followed by an unknown
// code); a four-entry queue between the classifier and the output stage
// absorbs these bursts, so input accepts continue while the output is stalled
// until the queue fills. The output is registered. The transaction carrying
// tlast also carries the unescaped frame length (saturated at MAX_FRAME) and
// tuser = 1 when the XOR of all bytes but the first and last is zero.
// ----------------------------------------------------------------------------
module frame_unescape_xor_check
    import fuxc_pkg::*;
#(
    parameter int MAX_FRAME = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tlast,   // in_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_byte, then frame_length, zero padded to bytes
    output logic [((8 + $clog2(MAX_FRAME + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                 m_axis_tlast,   // out_last
    output logic                 m_axis_tuser    // check_ok
);

    localparam int LEN_W  = $clog2(MAX_FRAME + 1);
    localparam int DATA_W = ((8 + LEN_W + 7) / 8) * 8;

    logic             push;
    pair_t            push_data;
    logic             full;
    logic             pop;
    pair_t            head;
    logic             empty;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] frame_length;

    fuxc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    fuxc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_data),
        .full    (full),
        .rd_en   (pop),
        .rd_data (head),
        .empty   (empty)
    );

    fuxc_back #(
        .MAX_FRAME (MAX_FRAME),
        .LEN_W     (LEN_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (out_byte),
        .out_last     (m_axis_tlast),
        .check_ok     (m_axis_tuser),
        .frame_length (frame_length)
    );

    assign m_axis_tdata = DATA_W'({frame_length, out_byte});

endmodule

@@ hdl/fuxc_front.sv @@
// ----------------------------------------------------------------------------
// fuxc_front
// Accepts escaped bytes, tracks the pending escape and classifies each byte
// into zero, one or two unescaped bytes for the queue.
// ----------------------------------------------------------------------------
module fuxc_front
    import fuxc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       full,
    output logic       push,
    output pair_t      push_data
);

    logic  pending_reg;
    logic  pending_next;
    logic  emit;
    logic  accept;
    pair_t pair;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pair         = '0;
        emit         = 1'b1;
        pending_next = pending_reg;
        if (pending_reg)
        begin
            pending_next = 1'b0;
            if (in_byte == ESC_CODE_ESC)
            begin
                pair.byte0 = ESC_BYTE;
                pair.last0 = in_last;
            end
            else if (in_byte == ESC_CODE_FLAG)
            begin
                pair.byte0 = FLAG_BYTE;
                pair.last0 = in_last;
            end
            else
            begin
                // unknown escape: 7D goes out raw, this byte handled normally
                pair.byte0 = ESC_BYTE;
                pair.last0 = 1'b0;
                if (in_byte == ESC_BYTE && !in_last)
                begin
                    pending_next = 1'b1;
                end
                else
                begin
                    pair.two   = 1'b1;
                    pair.byte1 = in_byte;
                    pair.last1 = in_last;
                end
            end
        end
        else if (in_byte == ESC_BYTE && !in_last)
        begin
            emit         = 1'b0;
            pending_next = 1'b1;
        end
        else
        begin
            pair.byte0 = in_byte;
            pair.last0 = in_last;
        end
        if (in_last)
        begin
            pending_next = 1'b0;
        end
    end

    assign push      = accept && emit;
    assign push_data = pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

@@ hdl/fuxc_fifo.sv @@
// ----------------------------------------------------------------------------
// fuxc_fifo
// Short register queue of byte pairs between the front and back parts.
// ----------------------------------------------------------------------------
module fuxc_fifo
    import fuxc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  pair_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output pair_t rd_data,
    output logic  empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pair_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/fuxc_back.sv @@
// ----------------------------------------------------------------------------
// fuxc_back
// Drains byte pairs one byte per cycle unless stalled, keeps the running XOR
// and the saturating length, and holds the registered output transaction.
// ----------------------------------------------------------------------------
module fuxc_back
    import fuxc_pkg::*;
#(
    parameter int MAX_FRAME = 1024,
    parameter int LEN_W     = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pair_t            head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             check_ok,
    output logic [LEN_W-1:0] frame_length
);

    logic             half_reg;
    logic [7:0]       xor_reg;
    logic [LEN_W-1:0] count_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             ok_reg;
    logic [LEN_W-1:0] len_reg;

    logic             load;
    logic [7:0]       sel_byte;
    logic             sel_last;
    logic [LEN_W-1:0] count_inc;

    assign load      = !empty && (!valid_reg || out_ready);
    assign sel_byte  = half_reg ? head.byte1 : head.byte0;
    assign sel_last  = half_reg ? head.last1 : head.last0;
    assign pop       = load && (half_reg || !head.two);
    assign count_inc = (count_reg < LEN_W'(MAX_FRAME)) ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= 1'b0;
            xor_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            last_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            len_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                byte_reg  <= sel_byte;
                last_reg  <= sel_last;
                half_reg  <= !pop;
                if (sel_last)
                begin
                    ok_reg    <= (xor_reg == '0);
                    len_reg   <= count_inc;
                    xor_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    ok_reg    <= 1'b0;
                    len_reg   <= '0;
                    count_reg <= count_inc;
                    // the first byte of a frame stays out of the check
                    if (count_reg != '0)
                    begin
                        xor_reg <= xor_reg ^ sel_byte;
                    end
                end
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_last     = last_reg;
    assign check_ok     = ok_reg;
    assign frame_length = len_reg;

endmodule
